// ----- design/sit_pkg.sv -----
`default_nettype none

package sit_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_CROSS    = 2'd0,
        ST_SHARED   = 2'd1,
        ST_PARALLEL = 2'd2,
        ST_OUTSIDE  = 2'd3
    } status_t;

    localparam int STATUS_W  = 2;
    localparam int OUT_W     = 24;   // width of each rounded coordinate
    localparam int CAP_LOG   = 50;   // quotient magnitude clamp is 2^CAP_LOG
    localparam int VAL_W     = 52;   // signed width of the clamped quotient
    localparam int M_TDATA_W = 56;   // status + two coordinates, byte aligned

endpackage

`default_nettype wire

// ----- design/sit_front.sv -----
`default_nettype none

// determinant, cramer numerators and early status, five register stages
module sit_front #(
    parameter int C = 16,
    parameter int F = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [8*C-1:0]             in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [3*C+3+F-1:0]              out_num_x,
    output logic [3*C+3+F-1:0]              out_num_y,
    output logic [2*C+1:0]                  out_den,
    output logic [8*C+3:0]                  out_side
);

    localparam int DF_W  = C + 1;
    localparam int PD_W  = 2 * C + 2;
    localparam int CP_W  = 2 * C;
    localparam int D_W   = 2 * C + 3;
    localparam int P_W   = 2 * C + 1;
    localparam int M_W   = 2 * C + 2;
    localparam int NP_W  = 3 * C + 2;
    localparam int N_W   = 3 * C + 3;
    localparam int NUM_W = N_W + F;

    // stage 1: registered coordinates
    logic                v1_reg;
    logic [8*C-1:0]      crd_reg;
    // stage 2: products of differences and of coordinates
    logic                v2_reg;
    logic                shared2_reg;
    logic signed [PD_W-1:0] p1_reg, p2_reg;
    logic signed [CP_W-1:0] q1_reg, q2_reg, q3_reg, q4_reg;
    logic signed [DF_W-1:0] dx12_2_reg, dy12_2_reg, dx34_2_reg, dy34_2_reg;
    logic [8*C-1:0]      box2_reg;
    // stage 3: determinant and cross terms
    logic                v3_reg;
    logic                shared3_reg;
    logic signed [D_W-1:0] d3_reg;
    logic signed [P_W-1:0] pre_reg, post_reg;
    logic signed [DF_W-1:0] dx12_3_reg, dy12_3_reg, dx34_3_reg, dy34_3_reg;
    logic [8*C-1:0]      box3_reg;
    // stage 4: numerator products
    logic                v4_reg;
    sit_pkg::status_t    st4_reg;
    logic                dneg4_reg;
    logic [M_W-1:0]      dmag4_reg;
    logic signed [NP_W-1:0] ax_reg, bx_reg, ay_reg, by_reg;
    logic [8*C-1:0]      box4_reg;
    // stage 5: divider operands
    logic                v5_reg;

    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) crd_reg <= in_data;
    end

    // stage 2 logic
    logic signed [C-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [DF_W-1:0] dx12, dy12, dx34, dy34;
    logic shared;
    logic [8*C-1:0] box;

    always_comb begin
        x1 = $signed(crd_reg[0*C +: C]);
        y1 = $signed(crd_reg[1*C +: C]);
        x2 = $signed(crd_reg[2*C +: C]);
        y2 = $signed(crd_reg[3*C +: C]);
        x3 = $signed(crd_reg[4*C +: C]);
        y3 = $signed(crd_reg[5*C +: C]);
        x4 = $signed(crd_reg[6*C +: C]);
        y4 = $signed(crd_reg[7*C +: C]);
        dx12 = DF_W'(x1) - DF_W'(x2);
        dy12 = DF_W'(y1) - DF_W'(y2);
        dx34 = DF_W'(x3) - DF_W'(x4);
        dy34 = DF_W'(y3) - DF_W'(y4);
        shared = (x1 == x3 && y1 == y3) || (x1 == x4 && y1 == y4) ||
                 (x2 == x3 && y2 == y3) || (x2 == x4 && y2 == y4);
        box[0*C +: C] = (x1 < x2) ? x1 : x2;
        box[1*C +: C] = (x1 > x2) ? x1 : x2;
        box[2*C +: C] = (x3 < x4) ? x3 : x4;
        box[3*C +: C] = (x3 > x4) ? x3 : x4;
        box[4*C +: C] = (y1 < y2) ? y1 : y2;
        box[5*C +: C] = (y1 > y2) ? y1 : y2;
        box[6*C +: C] = (y3 < y4) ? y3 : y4;
        box[7*C +: C] = (y3 > y4) ? y3 : y4;
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            shared2_reg <= shared;
            p1_reg      <= PD_W'(dx12) * PD_W'(dy34);
            p2_reg      <= PD_W'(dy12) * PD_W'(dx34);
            q1_reg      <= CP_W'(x1) * CP_W'(y2);
            q2_reg      <= CP_W'(y1) * CP_W'(x2);
            q3_reg      <= CP_W'(x3) * CP_W'(y4);
            q4_reg      <= CP_W'(y3) * CP_W'(x4);
            dx12_2_reg  <= dx12;
            dy12_2_reg  <= dy12;
            dx34_2_reg  <= dx34;
            dy34_2_reg  <= dy34;
            box2_reg    <= box;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            shared3_reg <= shared2_reg;
            d3_reg      <= D_W'(p1_reg) - D_W'(p2_reg);
            pre_reg     <= P_W'(q1_reg) - P_W'(q2_reg);
            post_reg    <= P_W'(q3_reg) - P_W'(q4_reg);
            dx12_3_reg  <= dx12_2_reg;
            dy12_3_reg  <= dy12_2_reg;
            dx34_3_reg  <= dx34_2_reg;
            dy34_3_reg  <= dy34_2_reg;
            box3_reg    <= box2_reg;
        end
    end

    // stage 4 logic
    logic signed [D_W-1:0] dabs;
    sit_pkg::status_t st;

    always_comb begin
        dabs = d3_reg[D_W-1] ? -d3_reg : d3_reg;
        if (shared3_reg)       st = sit_pkg::ST_SHARED;
        else if (d3_reg == '0) st = sit_pkg::ST_PARALLEL;
        else                   st = sit_pkg::ST_CROSS;
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            st4_reg   <= st;
            dneg4_reg <= d3_reg[D_W-1];
            dmag4_reg <= dabs[M_W-1:0];
            ax_reg    <= NP_W'(pre_reg) * NP_W'(dx34_3_reg);
            bx_reg    <= NP_W'(dx12_3_reg) * NP_W'(post_reg);
            ay_reg    <= NP_W'(pre_reg) * NP_W'(dy34_3_reg);
            by_reg    <= NP_W'(dy12_3_reg) * NP_W'(post_reg);
            box4_reg  <= box3_reg;
        end
    end

    // stage 5 logic
    logic signed [N_W-1:0] nx, ny, nxa, nya;

    always_comb begin
        nx  = N_W'(ax_reg) - N_W'(bx_reg);
        ny  = N_W'(ay_reg) - N_W'(by_reg);
        nxa = nx[N_W-1] ? -nx : nx;
        nya = ny[N_W-1] ? -ny : ny;
    end

    always_ff @(posedge aclk) begin
        if (rdy5 && v4_reg) begin
            out_num_x <= NUM_W'(unsigned'(nxa)) << F;
            out_num_y <= NUM_W'(unsigned'(nya)) << F;
            out_den   <= dmag4_reg;
            out_side  <= {st4_reg, ny[N_W-1] ^ dneg4_reg, nx[N_W-1] ^ dneg4_reg, box4_reg};
        end
    end

endmodule

`default_nettype wire

// ----- design/sit_div_cell.sv -----
`default_nettype none

// one restoring division step for both coordinates, one quotient bit per cell
module sit_div_cell #(
    parameter int NUM_W = 59,
    parameter int M_W   = 34,
    parameter int SD_W  = 132
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [NUM_W-1:0] in_num_x,
    input  wire logic [NUM_W-1:0] in_num_y,
    input  wire logic [NUM_W-1:0] in_q_x,
    input  wire logic [NUM_W-1:0] in_q_y,
    input  wire logic [M_W-1:0]   in_rem_x,
    input  wire logic [M_W-1:0]   in_rem_y,
    input  wire logic [M_W-1:0]   in_den,
    input  wire logic [SD_W-1:0]  in_side,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [NUM_W-1:0]      out_num_x,
    output logic [NUM_W-1:0]      out_num_y,
    output logic [NUM_W-1:0]      out_q_x,
    output logic [NUM_W-1:0]      out_q_y,
    output logic [M_W-1:0]        out_rem_x,
    output logic [M_W-1:0]        out_rem_y,
    output logic [M_W-1:0]        out_den,
    output logic [SD_W-1:0]       out_side
);

    logic          valid_reg;
    logic [M_W:0]  sx, sy, tx, ty;
    logic          gx, gy;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_comb begin
        sx = {in_rem_x, in_num_x[NUM_W-1]};
        sy = {in_rem_y, in_num_y[NUM_W-1]};
        gx = sx >= {1'b0, in_den};
        gy = sy >= {1'b0, in_den};
        tx = gx ? sx - {1'b0, in_den} : sx;
        ty = gy ? sy - {1'b0, in_den} : sy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (in_ready) valid_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            out_num_x <= in_num_x << 1;
            out_num_y <= in_num_y << 1;
            out_q_x   <= {in_q_x[NUM_W-2:0], gx};
            out_q_y   <= {in_q_y[NUM_W-2:0], gy};
            out_rem_x <= tx[M_W-1:0];
            out_rem_y <= ty[M_W-1:0];
            out_den   <= in_den;
            out_side  <= in_side;
        end
    end

endmodule

`default_nettype wire

// ----- design/sit_back.sv -----
`default_nettype none

// rounding, clamp, bounds test and saturation, two register stages
module sit_back #(
    parameter int C     = 16,
    parameter int F     = 8,
    parameter int NUM_W = 59,
    parameter int M_W   = 34,
    parameter int SD_W  = 132
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [NUM_W-1:0] in_q_x,
    input  wire logic [NUM_W-1:0] in_q_y,
    input  wire logic [M_W-1:0]   in_rem_x,
    input  wire logic [M_W-1:0]   in_rem_y,
    input  wire logic [M_W-1:0]   in_den,
    input  wire logic [SD_W-1:0]  in_side,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [sit_pkg::M_TDATA_W-1:0] out_data
);

    localparam int VW   = sit_pkg::VAL_W;
    localparam int QR_W = NUM_W + 1;
    localparam int QE_W = (QR_W > VW) ? QR_W : VW;
    localparam logic [QE_W-1:0] CAP = QE_W'(1) << sit_pkg::CAP_LOG;
    localparam logic signed [VW-1:0] SAT_MAX = VW'((1 << (sit_pkg::OUT_W - 1)) - 1);
    localparam logic signed [VW-1:0] SAT_MIN = -VW'(1 << (sit_pkg::OUT_W - 1));

    logic                    v1_reg, v2_reg;
    logic                    rdy1, rdy2;
    logic signed [VW-1:0]    vx_reg, vy_reg;
    logic [SD_W-1:0]         side_reg;

    assign rdy2      = !v2_reg || out_ready;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    function automatic logic signed [VW-1:0] round_clamp(
        input logic [NUM_W-1:0] q,
        input logic [M_W-1:0]   rem,
        input logic [M_W-1:0]   den,
        input logic             neg
    );
        logic [QE_W-1:0] qe;
        logic [VW-1:0]   m;
        qe = QE_W'(q) + QE_W'({rem, 1'b0} >= {1'b0, den});
        if (qe > CAP) qe = CAP;
        m = qe[VW-1:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            vx_reg   <= round_clamp(in_q_x, in_rem_x, in_den, in_side[8*C]);
            vy_reg   <= round_clamp(in_q_y, in_rem_y, in_den, in_side[8*C+1]);
            side_reg <= in_side;
        end
    end

    function automatic logic in_box(
        input logic signed [VW-1:0] v,
        input logic [C-1:0]         lo,
        input logic [C-1:0]         hi
    );
        logic signed [VW-1:0] l, h;
        l = (VW'($signed(lo)) <<< F) - VW'(1);
        h = (VW'($signed(hi)) <<< F) + VW'(1);
        return (v >= l) && (v <= h);
    endfunction

    function automatic logic [sit_pkg::OUT_W-1:0] sat(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] s;
        s = (v > SAT_MAX) ? SAT_MAX : ((v < SAT_MIN) ? SAT_MIN : v);
        return s[sit_pkg::OUT_W-1:0];
    endfunction

    sit_pkg::status_t st_in, st_out;
    logic             in_bounds;
    logic [sit_pkg::OUT_W-1:0] ox, oy;

    always_comb begin
        st_in  = sit_pkg::status_t'(side_reg[8*C+2 +: sit_pkg::STATUS_W]);
        in_bounds = in_box(vx_reg, side_reg[0*C +: C], side_reg[1*C +: C]) &&
                    in_box(vx_reg, side_reg[2*C +: C], side_reg[3*C +: C]) &&
                    in_box(vy_reg, side_reg[4*C +: C], side_reg[5*C +: C]) &&
                    in_box(vy_reg, side_reg[6*C +: C], side_reg[7*C +: C]);
        ox = '0;
        oy = '0;
        case (st_in)
            sit_pkg::ST_CROSS: begin
                st_out = in_bounds ? sit_pkg::ST_CROSS : sit_pkg::ST_OUTSIDE;
                ox     = sat(vx_reg);
                oy     = sat(vy_reg);
            end
            default: st_out = st_in;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            out_data <= sit_pkg::M_TDATA_W'({oy, ox, st_out});
        end
    end

endmodule

`default_nettype wire

// ----- design/segment_intersection_test_unit.sv -----
`default_nettype none

// Segment intersection test. Each transaction on the s_ side carries two line
// segments as eight signed integer endpoint coordinates; each yields exactly one
// transaction on the m_ side with a status (crossing, shared endpoint, parallel,
// outside bounds) and the crossing point rounded half away from zero to fixed
// point with FRACTION_BITS fraction bits, saturated to 24 bits. One pair is
// accepted every cycle while s_tready is high. The pipeline has five front stages
// for the determinant and numerators, one divider cell per quotient bit
// (3*COORD_BITS+3+FRACTION_BITS cells, the two coordinates divided side by
// side), and two stages for rounding, bounds and saturation.
// Ready ripples through every stage in the same cycle, so a stall reaches
// s_tready only once every stage is full and bubbles are squeezed out.
module segment_intersection_test_unit #(
    parameter int FRACTION_BITS = 8,
    parameter int COORD_BITS    = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  wire logic [8*COORD_BITS-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status[1:0], cross_x[25:2], cross_y[49:26], zero fill
    output logic [sit_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRACTION_BITS;
    localparam int NUM_W = 3 * C + 3 + F;   // shifted numerator magnitude
    localparam int M_W   = 2 * C + 2;       // determinant magnitude
    localparam int SD_W  = 8 * C + 4;       // status, signs and boxes

    // chain links: index k feeds cell k, index NUM_W is the last cell's output
    logic             lv   [NUM_W+1];
    logic             lr   [NUM_W+1];
    logic [NUM_W-1:0] lnx  [NUM_W+1];
    logic [NUM_W-1:0] lny  [NUM_W+1];
    logic [NUM_W-1:0] lqx  [NUM_W+1];
    logic [NUM_W-1:0] lqy  [NUM_W+1];
    logic [M_W-1:0]   lrx  [NUM_W+1];
    logic [M_W-1:0]   lry  [NUM_W+1];
    logic [M_W-1:0]   lden [NUM_W+1];
    logic [SD_W-1:0]  lsd  [NUM_W+1];

    // determinant, numerators and early status
    sit_front #(.C(C), .F(F)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (lv[0]),
        .out_ready (lr[0]),
        .out_num_x (lnx[0]),
        .out_num_y (lny[0]),
        .out_den   (lden[0]),
        .out_side  (lsd[0])
    );

    // partial quotient and remainder start from zero
    assign lqx[0] = '0;
    assign lqy[0] = '0;
    assign lrx[0] = '0;
    assign lry[0] = '0;

    // row of division cells, most significant quotient bit first
    for (genvar k = 0; k < NUM_W; k++) begin : g_cell
        sit_div_cell #(.NUM_W(NUM_W), .M_W(M_W), .SD_W(SD_W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (lv[k]),
            .in_ready  (lr[k]),
            .in_num_x  (lnx[k]),
            .in_num_y  (lny[k]),
            .in_q_x    (lqx[k]),
            .in_q_y    (lqy[k]),
            .in_rem_x  (lrx[k]),
            .in_rem_y  (lry[k]),
            .in_den    (lden[k]),
            .in_side   (lsd[k]),
            .out_valid (lv[k+1]),
            .out_ready (lr[k+1]),
            .out_num_x (lnx[k+1]),
            .out_num_y (lny[k+1]),
            .out_q_x   (lqx[k+1]),
            .out_q_y   (lqy[k+1]),
            .out_rem_x (lrx[k+1]),
            .out_rem_y (lry[k+1]),
            .out_den   (lden[k+1]),
            .out_side  (lsd[k+1])
        );
    end

    // rounding, bounds and the output register
    sit_back #(.C(C), .F(F), .NUM_W(NUM_W), .M_W(M_W), .SD_W(SD_W)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lv[NUM_W]),
        .in_ready  (lr[NUM_W]),
        .in_q_x    (lqx[NUM_W]),
        .in_q_y    (lqy[NUM_W]),
        .in_rem_x  (lrx[NUM_W]),
        .in_rem_y  (lry[NUM_W]),
        .in_den    (lden[NUM_W]),
        .in_side   (lsd[NUM_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- design/sit_checker.sv -----
`default_nettype none

module sit_checker #(
    parameter int COORD_BITS = 16
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [8*COORD_BITS-1:0]       s_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [sit_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an empty pipeline always takes input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // shared endpoint and parallel results carry no point
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == sit_pkg::ST_SHARED ||
                     m_tdata[1:0] == sit_pkg::ST_PARALLEL) |-> m_tdata[49:2] == '0)
        else $error("point not zero for degenerate pair");

endmodule

bind segment_intersection_test_unit sit_checker #(.COORD_BITS(COORD_BITS)) u_sit_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
